/* hdl/pffl_pkg.sv */
// ----------------------------------------------------------------------------
// pffl_pkg: page frame free list allocator shared definitions
// Frame and link widths, command and result types, list helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pffl_pkg;

  // Frame store geometry
  localparam int FRAME_COUNT = 65536;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int LINK_W      = $clog2(FRAME_COUNT + 1);
  localparam int PAGE_W      = 16;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [LINK_W-1:0]  link_t;

  // Link value that marks the end of a list
  localparam link_t LINK_NONE = LINK_W'(FRAME_COUNT);

  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_FREE       = 2'd1,
    ACT_ZERO_PAGE  = 2'd2,
    ACT_ZERO_FIRST = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_PAGE  = 3'd1,
    STAT_IN_USE   = 3'd2,
    STAT_ZEROED   = 3'd3,
    STAT_NOT_USED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_USED   = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ZEROED = 2'd2
  } kind_e;

  typedef struct packed {
    action_e             action;
    logic [PAGE_W-1:0]   page_number;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [PAGE_W-1:0]   granted_page;
    logic                granted_zeroed;
    logic                clear_request;
  } result_t;

  // Head and tail of one list
  typedef struct packed {
    link_t head;
    link_t tail;
  } list_t;

  // Link table and kind table writes for one write step
  typedef struct packed {
    logic   next_en;
    frame_t next_addr;
    link_t  next_data;
    logic   prev_en;
    frame_t prev_addr;
    link_t  prev_data;
    logic   kind_en;
    frame_t kind_addr;
    kind_e  kind_data;
  } wr_plan_t;

  function automatic logic link_valid(link_t l);
    return l < LINK_NONE;
  endfunction

  // Head/tail update when frame f (links nx, pv) leaves the list
  function automatic list_t list_unlink(list_t l, link_t f, link_t nx, link_t pv);
    list_t r;
    r = l;
    if (r.head == f) begin
      r.head = nx;
      if (r.head == LINK_NONE) r.tail = LINK_NONE;
    end
    if (r.tail == f) begin
      r.tail = pv;
      if (r.tail == LINK_NONE) r.head = LINK_NONE;
    end
    return r;
  endfunction

  // Head/tail update when frame f joins the tail of the list
  function automatic list_t list_append(list_t l, link_t f);
    list_t r;
    r = l;
    if (!link_valid(l.head) || !link_valid(l.tail)) begin
      r.head = f;
      r.tail = f;
    end else begin
      r.tail = f;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/pffl_ram.sv */
// ----------------------------------------------------------------------------
// pffl_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/page_frame_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_top: physical page frame allocator
// Zeroed and free frame lists kept as doubly linked lists in link RAMs.
// ----------------------------------------------------------------------------
// A command transfers at a rising edge with start_i high and busy_o low. After
// reset the block first sweeps the frame kind RAM to "used", one entry per
// cycle, for FRAME_COUNT (65536) entries with busy_o high. Each command then
// reads the kind and both links of its frame together and writes the link
// and kind RAMs back, one write per RAM per cycle. Every command yields one
// result on result_o, marked by done_o for one cycle, in the cycle after its
// last write (after its evaluation if it writes nothing); results cannot be
// held off, and result_o keeps only the latest one.
`default_nettype none

module page_frame_free_list_allocator_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire pffl_pkg::cmd_t    cmd_i,
  output logic                   busy_o,
  output logic                   done_o,
  output pffl_pkg::result_t      result_o
);

  import pffl_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ADDR  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  localparam frame_t CLEAR_LAST = FRAME_W'(FRAME_COUNT - 1);

  state_e   st_q, st_d;
  frame_t   clr_q, clr_d;
  logic [1:0] wleft_q, wleft_d;
  logic     done_q, done_d;
  list_t    zero_q, zero_d;
  list_t    free_q, free_d;

  // Latched command
  action_e  action_q;
  link_t    f_q;
  logic     f_ok_q;
  logic     from_zero_q;
  result_t  res_q, res_d;
  wr_plan_t plan_q [3];
  wr_plan_t plan_d [3];
  logic [1:0] nwr;

  logic     accept;
  link_t    f_sel;
  logic     f_sel_ok;
  logic     from_zero_sel;

  // RAM ports
  link_t    next_rdata, prev_rdata;
  logic [1:0] kind_rdata;
  logic     next_we, prev_we, kind_we;
  frame_t   next_waddr, prev_waddr, kind_waddr;
  link_t    next_wdata, prev_wdata;
  kind_e    kind_wdata;

  // Busy drops in the last write cycle: the next read follows that write
  assign busy_o = !((st_q == ST_IDLE) || ((st_q == ST_WRITE) && (wleft_q == 2'd0)));
  assign accept = start_i && !busy_o;

  // Frame selection at transfer time
  always_comb begin
    f_sel         = LINK_W'(cmd_i.page_number);
    f_sel_ok      = 32'(cmd_i.page_number) < FRAME_COUNT;
    from_zero_sel = 1'b0;
    case (cmd_i.action)
      ACT_ALLOC: begin
        if (link_valid(zero_q.head)) begin
          f_sel         = zero_q.head;
          from_zero_sel = 1'b1;
        end else begin
          f_sel = free_q.head;
        end
        f_sel_ok = link_valid(f_sel);
      end
      ACT_ZERO_FIRST: begin
        f_sel    = free_q.head;
        f_sel_ok = link_valid(free_q.head);
      end
      default: begin
      end
    endcase
  end

  // Evaluate the command once kind and links are read
  always_comb begin
    list_t sel;
    logic  empty;
    sel        = from_zero_q ? zero_q : free_q;
    empty      = 1'b0;
    res_d      = '0;
    res_d.status = STAT_OK;
    plan_d[0]  = '0;
    plan_d[1]  = '0;
    plan_d[2]  = '0;
    nwr        = 2'd0;
    zero_d     = zero_q;
    free_d     = free_q;
    case (action_q)
      ACT_ALLOC: begin
        if (!f_ok_q) begin
          res_d.status = STAT_NO_PAGE;
        end else begin
          res_d.granted_page   = PAGE_W'(f_q);
          res_d.granted_zeroed = from_zero_q;
          plan_d[0].kind_en   = 1'b1;
          plan_d[0].kind_addr = f_q[FRAME_W-1:0];
          plan_d[0].kind_data = KIND_USED;
          plan_d[0].prev_en   = link_valid(next_rdata);
          plan_d[0].prev_addr = next_rdata[FRAME_W-1:0];
          plan_d[0].prev_data = prev_rdata;
          plan_d[0].next_en   = link_valid(prev_rdata);
          plan_d[0].next_addr = prev_rdata[FRAME_W-1:0];
          plan_d[0].next_data = next_rdata;
          nwr = 2'd1;
          if (from_zero_q) begin
            zero_d = list_unlink(sel, f_q, next_rdata, prev_rdata);
          end else begin
            free_d = list_unlink(sel, f_q, next_rdata, prev_rdata);
          end
        end
      end
      ACT_FREE: begin
        if (!f_ok_q || (kind_e'(kind_rdata) != KIND_USED)) begin
          res_d.status = STAT_NOT_USED;
        end else begin
          empty = !link_valid(free_q.head) || !link_valid(free_q.tail);
          plan_d[0].kind_en   = 1'b1;
          plan_d[0].kind_addr = f_q[FRAME_W-1:0];
          plan_d[0].kind_data = KIND_FREE;
          plan_d[0].next_en   = !empty;
          plan_d[0].next_addr = free_q.tail[FRAME_W-1:0];
          plan_d[0].next_data = f_q;
          plan_d[0].prev_en   = 1'b1;
          plan_d[0].prev_addr = f_q[FRAME_W-1:0];
          plan_d[0].prev_data = empty ? LINK_NONE : free_q.tail;
          plan_d[1].next_en   = 1'b1;
          plan_d[1].next_addr = f_q[FRAME_W-1:0];
          plan_d[1].next_data = LINK_NONE;
          nwr    = 2'd2;
          free_d = list_append(free_q, f_q);
        end
      end
      ACT_ZERO_PAGE, ACT_ZERO_FIRST: begin
        if (!f_ok_q) begin
          res_d.status = (action_q == ACT_ZERO_FIRST) ? STAT_NO_PAGE : STAT_IN_USE;
        end else if (kind_e'(kind_rdata) == KIND_ZEROED) begin
          res_d.status = STAT_ZEROED;
        end else if (kind_e'(kind_rdata) != KIND_FREE) begin
          res_d.status = STAT_IN_USE;
        end else begin
          empty = !link_valid(zero_q.head) || !link_valid(zero_q.tail);
          res_d.granted_page  = PAGE_W'(f_q);
          res_d.clear_request = 1'b1;
          // Unlink from the free list
          plan_d[0].kind_en   = 1'b1;
          plan_d[0].kind_addr = f_q[FRAME_W-1:0];
          plan_d[0].kind_data = KIND_ZEROED;
          plan_d[0].prev_en   = link_valid(next_rdata);
          plan_d[0].prev_addr = next_rdata[FRAME_W-1:0];
          plan_d[0].prev_data = prev_rdata;
          plan_d[0].next_en   = link_valid(prev_rdata);
          plan_d[0].next_addr = prev_rdata[FRAME_W-1:0];
          plan_d[0].next_data = next_rdata;
          // Append to the zeroed list
          plan_d[1].next_en   = !empty;
          plan_d[1].next_addr = zero_q.tail[FRAME_W-1:0];
          plan_d[1].next_data = f_q;
          plan_d[1].prev_en   = 1'b1;
          plan_d[1].prev_addr = f_q[FRAME_W-1:0];
          plan_d[1].prev_data = empty ? LINK_NONE : zero_q.tail;
          plan_d[2].next_en   = 1'b1;
          plan_d[2].next_addr = f_q[FRAME_W-1:0];
          plan_d[2].next_data = LINK_NONE;
          nwr    = 2'd3;
          free_d = list_unlink(free_q, f_q, next_rdata, prev_rdata);
          zero_d = list_append(zero_q, f_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    st_d    = st_q;
    clr_d   = clr_q;
    wleft_d = wleft_q;
    done_d  = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLEAR_LAST) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) st_d = ST_ADDR;
      end
      ST_ADDR: begin
        st_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (nwr == 2'd0) begin
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          wleft_d = nwr - 2'd1;
          st_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (wleft_q == 2'd0) begin
          done_d = 1'b1;
          st_d   = accept ? ST_ADDR : ST_IDLE;
        end else begin
          wleft_d = wleft_q - 2'd1;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_CLEAR;
      clr_q   <= '0;
      wleft_q <= '0;
      done_q  <= 1'b0;
      zero_q  <= '{head: LINK_NONE, tail: LINK_NONE};
      free_q  <= '{head: LINK_NONE, tail: LINK_NONE};
    end else begin
      st_q    <= st_d;
      clr_q   <= clr_d;
      wleft_q <= wleft_d;
      done_q  <= done_d;
      if (st_q == ST_EVAL) begin
        zero_q <= zero_d;
        free_q <= free_d;
      end
    end
  end

  // Command, result and write plan registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q    <= cmd_i.action;
      f_q         <= f_sel;
      f_ok_q      <= f_sel_ok;
      from_zero_q <= from_zero_sel;
    end
    if (st_q == ST_EVAL) begin
      res_q     <= res_d;
      plan_q[0] <= plan_d[0];
      plan_q[1] <= plan_d[1];
      plan_q[2] <= plan_d[2];
    end else if (st_q == ST_WRITE) begin
      plan_q[0] <= plan_q[1];
      plan_q[1] <= plan_q[2];
      plan_q[2] <= '0;
    end
  end

  // RAM write muxing: clearing sweep or current write plan
  always_comb begin
    next_we    = (st_q == ST_WRITE) && plan_q[0].next_en;
    next_waddr = plan_q[0].next_addr;
    next_wdata = plan_q[0].next_data;
    prev_we    = (st_q == ST_WRITE) && plan_q[0].prev_en;
    prev_waddr = plan_q[0].prev_addr;
    prev_wdata = plan_q[0].prev_data;
    if (st_q == ST_CLEAR) begin
      kind_we    = 1'b1;
      kind_waddr = clr_q;
      kind_wdata = KIND_USED;
    end else begin
      kind_we    = (st_q == ST_WRITE) && plan_q[0].kind_en;
      kind_waddr = plan_q[0].kind_addr;
      kind_wdata = plan_q[0].kind_data;
    end
  end

  pffl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (FRAME_COUNT)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (f_q[FRAME_W-1:0]),
    .rdata_o (next_rdata)
  );

  pffl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (FRAME_COUNT)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (f_q[FRAME_W-1:0]),
    .rdata_o (prev_rdata)
  );

  pffl_ram #(
    .WIDTH (2),
    .DEPTH (FRAME_COUNT)
  ) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (kind_we),
    .waddr_i (kind_waddr),
    .wdata_i (kind_wdata),
    .raddr_i (f_q[FRAME_W-1:0]),
    .rdata_o (kind_rdata)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> busy_o)
    else $error("command transfer possible during kind table sweep");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == ST_ADDR))
    else $error("accepted command did not start its read");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> ((st_q == ST_EVAL) || (st_q == ST_WRITE)))
    else $error("result strobe outside a finishing state");

  a_clear_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.clear_request) |->
      ((result_o.status == STAT_OK) && !result_o.granted_zeroed))
    else $error("clear request on a failed or allocate result");

  a_write_only_planned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_we || prev_we) |-> (st_q == ST_WRITE))
    else $error("link table write outside the write phase");

endmodule

`default_nettype wire
